/* hdl/c2p_pkg.sv */
// Shared types and constants for the rectangular to polar converter.
// No dependencies; every module of the block imports this package.
package c2p_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int GUARD_BITS = 24;
    localparam int TURN_W     = 32;
    localparam int ATAN_LEN   = 24;
    localparam int LEN_SQ_W   = 32;
    localparam int LEN_W      = 16;

    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    localparam logic [TURN_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic x_neg;
        logic y_neg;
    } t_flags;

endpackage

/* hdl/c2p_front.sv */
// Input register, magnitude squaring and CORDIC preload for the converter.
// Depends on c2p_pkg.
module c2p_front
    import c2p_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int XW = COORD_WIDTH_DEF + GUARD_BITS + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [CW-1:0]        i_x,
    input  logic [CW-1:0]        i_y,
    output logic                 o_vld,
    output logic [2*CW-1:0]      o_sq,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic [TURN_W-1:0]    o_z,
    output t_flags               o_flags
);

    localparam int SQ_W = 2 * CW;

    logic                 r1_vld, r2_vld, r3_vld, r4_vld;
    logic [CW-1:0]        r1_x, r1_y;
    logic [CW-1:0]        r2_ax, r2_ay;
    logic signed [XW-1:0] r2_cx, r2_cy, r3_cx, r3_cy, r4_cx, r4_cy;
    logic [TURN_W-1:0]    r2_z, r3_z, r4_z;
    t_flags               r2_flags, r3_flags, r4_flags;
    logic [SQ_W-1:0]      r3_sqx, r3_sqy, r4_sq;

    logic                 n_xneg, n_yneg;
    logic [CW-1:0]        n_ax, n_ay;
    logic signed [XW-1:0] n_xe, n_ye, n_cx, n_cy;
    logic [TURN_W-1:0]    n_z;
    t_flags               n_flags;
    logic [SQ_W-1:0]      n_sqx, n_sqy;

    always_comb begin
        n_xneg  = r1_x[CW-1];
        n_yneg  = r1_y[CW-1];
        n_ax    = n_xneg ? CW'(-r1_x) : r1_x;
        n_ay    = n_yneg ? CW'(-r1_y) : r1_y;
        n_xe    = {{(XW-CW){r1_x[CW-1]}}, r1_x};
        n_ye    = {{(XW-CW){r1_y[CW-1]}}, r1_y};
        // fold the left half-plane onto the right one
        if (n_xneg) begin
            n_cx = (-n_xe) <<< GUARD_BITS;
            n_cy = (-n_ye) <<< GUARD_BITS;
            n_z  = HALF_TURN;
        end else begin
            n_cx = n_xe <<< GUARD_BITS;
            n_cy = n_ye <<< GUARD_BITS;
            n_z  = '0;
        end
        n_flags.x_zero = (r1_x == '0);
        n_flags.y_zero = (r1_y == '0);
        n_flags.x_neg  = n_xneg;
        n_flags.y_neg  = n_yneg;
    end

    assign n_sqx = r2_ax * r2_ax;
    assign n_sqy = r2_ay * r2_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x     <= i_x;
        r1_y     <= i_y;
        r2_ax    <= n_ax;
        r2_ay    <= n_ay;
        r2_cx    <= n_cx;
        r2_cy    <= n_cy;
        r2_z     <= n_z;
        r2_flags <= n_flags;
        r3_sqx   <= n_sqx;
        r3_sqy   <= n_sqy;
        r3_cx    <= r2_cx;
        r3_cy    <= r2_cy;
        r3_z     <= r2_z;
        r3_flags <= r2_flags;
        r4_sq    <= r3_sqx + r3_sqy;
        r4_cx    <= r3_cx;
        r4_cy    <= r3_cy;
        r4_z     <= r3_z;
        r4_flags <= r3_flags;
    end

    assign o_vld   = r4_vld;
    assign o_sq    = r4_sq;
    assign o_x     = r4_cx;
    assign o_y     = r4_cy;
    assign o_z     = r4_z;
    assign o_flags = r4_flags;

endmodule

/* hdl/c2p_sqrt_step.sv */
// One registered step of the restoring integer square root, two bits a step.
// Depends on c2p_pkg for default widths.
module c2p_sqrt_step
    import c2p_pkg::*;
#(
    parameter int STEPS = COORD_WIDTH_DEF,
    parameter int STEP  = 0
) (
    input  logic                 i_clk,
    input  logic [2*STEPS-1:0]   i_rem,
    input  logic [2*STEPS-1:0]   i_root,
    output logic [2*STEPS-1:0]   o_rem,
    output logic [2*STEPS-1:0]   o_root
);

    localparam int SQ_W  = 2 * STEPS;
    localparam int SHIFT = (STEP < STEPS) ? 2 * (STEPS - 1 - STEP) : 0;
    localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << SHIFT;

    logic [SQ_W-1:0] r_rem, r_root;
    logic [SQ_W-1:0] n_rem, n_root;

    generate
        if (STEP < STEPS) begin : g_active
            logic [SQ_W-1:0] trial;
            assign trial = i_root + BIT_VAL;
            always_comb begin
                if (i_rem >= trial) begin
                    n_rem  = i_rem - trial;
                    n_root = (i_root >> 1) + BIT_VAL;
                end else begin
                    n_rem  = i_rem;
                    n_root = i_root >> 1;
                end
            end
        end else begin : g_hold
            assign n_rem  = i_rem;
            assign n_root = i_root;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

/* hdl/c2p_cordic_step.sv */
// One registered vectoring CORDIC micro-rotation with angle accumulation.
// Depends on c2p_pkg for the arctangent table and widths.
module c2p_cordic_step
    import c2p_pkg::*;
#(
    parameter int XW    = COORD_WIDTH_DEF + GUARD_BITS + 2,
    parameter int STEPS = CORDIC_STAGES_DEF,
    parameter int STEP  = 0
) (
    input  logic                 i_clk,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic [TURN_W-1:0]    i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic [TURN_W-1:0]    o_z
);

    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic [TURN_W-1:0]    r_z, n_z;

    generate
        if (STEP < STEPS) begin : g_active
            logic signed [XW-1:0] dx, dy;
            assign dx = i_y >>> STEP;
            assign dy = i_x >>> STEP;
            always_comb begin
                if (!i_y[XW-1]) begin
                    n_x = i_x + dx;
                    n_y = i_y - dy;
                    n_z = i_z + ATAN_TURNS[STEP];
                end else begin
                    n_x = i_x - dx;
                    n_y = i_y + dy;
                    n_z = i_z - ATAN_TURNS[STEP];
                end
            end
        end else begin : g_hold
            assign n_x = i_x;
            assign n_y = i_y;
            assign n_z = i_z;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

/* hdl/c2p_back.sv */
// Output stage: root rounding, saturation, axis and zero-vector angle override.
// Depends on c2p_pkg.
module c2p_back
    import c2p_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int AW = ANGLE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [2*CW-1:0]     i_sq,
    input  logic [2*CW-1:0]     i_rem,
    input  logic [2*CW-1:0]     i_root,
    input  logic [TURN_W-1:0]   i_z,
    input  t_flags              i_flags,
    output logic                o_vld,
    output logic [LEN_SQ_W-1:0] o_len_sq,
    output logic [LEN_W-1:0]    o_len,
    output logic [AW-1:0]       o_dir,
    output logic                o_undef
);

    localparam int SQ_W   = 2 * CW;
    localparam int SQ_EXT = (SQ_W > LEN_SQ_W) ? SQ_W : LEN_SQ_W;
    localparam logic [SQ_EXT-1:0] SQ_MAX  = SQ_EXT'({LEN_SQ_W{1'b1}});
    localparam logic [SQ_W-1:0]   LEN_MAX = SQ_W'({LEN_W{1'b1}});
    localparam logic [TURN_W-1:0] DIR_RND = TURN_W'(1) << (TURN_W - 1 - AW);
    localparam logic [AW-1:0] DIR_QUARTER = AW'(1) << (AW - 2);
    localparam logic [AW-1:0] DIR_HALF    = AW'(1) << (AW - 1);
    localparam logic [AW-1:0] DIR_3QUART  = AW'(3) << (AW - 2);

    logic                r_vld;
    logic [LEN_SQ_W-1:0] r_len_sq, n_len_sq;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [AW-1:0]       r_dir, n_dir;
    logic                r_undef, n_undef;

    logic [SQ_EXT-1:0]   sq_ext;
    logic [SQ_W-1:0]     rnd;
    logic [TURN_W-1:0]   z_rnd;

    always_comb begin
        sq_ext   = SQ_EXT'(i_sq);
        n_len_sq = (sq_ext > SQ_MAX) ? {LEN_SQ_W{1'b1}} : sq_ext[LEN_SQ_W-1:0];
        rnd      = i_root + SQ_W'(i_rem > i_root);
        n_len    = (rnd > LEN_MAX) ? {LEN_W{1'b1}} : rnd[LEN_W-1:0];
        z_rnd    = i_z + DIR_RND;
        n_undef  = i_flags.x_zero & i_flags.y_zero;
        if (n_undef) begin
            n_dir = '0;
        end else if (i_flags.y_zero) begin
            n_dir = i_flags.x_neg ? DIR_HALF : '0;
        end else if (i_flags.x_zero) begin
            n_dir = i_flags.y_neg ? DIR_3QUART : DIR_QUARTER;
        end else begin
            n_dir = z_rnd[TURN_W-1 -: AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_sq <= n_len_sq;
        r_len    <= n_len;
        r_dir    <= n_dir;
        r_undef  <= n_undef;
    end

    assign o_vld    = r_vld;
    assign o_len_sq = r_len_sq;
    assign o_len    = r_len;
    assign o_dir    = r_dir;
    assign o_undef  = r_undef;

endmodule

/* hdl/cartesian_to_polar.sv */
// Top level of the rectangular to polar converter: front end, square root and
// CORDIC step pipeline, output stage. Depends on c2p_pkg and all c2p_ modules.
//
// Usage:
//   Drive i_x_coord / i_y_coord and raise start for one cycle per request.
//   busy is always low: a request is taken at every clock edge with start
//   high, one per cycle, back to back without limit.
//   Each result appears on o_length_squared, o_length, o_direction and
//   o_undefined_angle for exactly one cycle while o_valid is high.
//   Pipeline: four front stages for input, squaring and sum, the first
//   loaded at the request edge, one stage per square root / CORDIC step,
//   one output stage.
//   Throughput: one result per cycle, set by the fully pipelined steps.
//   Results leave in request order and cannot be held off.
//   Reset (i_rst_n low at a clock edge) clears all valid bits; requests in
//   flight are dropped and no strobe follows until new requests arrive.
//   The zero vector sets o_undefined_angle and gives direction 0.
module cartesian_to_polar
    import c2p_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] i_x_coord,
    input  logic [COORD_WIDTH-1:0] i_y_coord,
    output logic                   o_valid,
    output logic [LEN_SQ_W-1:0]    o_length_squared,
    output logic [LEN_W-1:0]       o_length,
    output logic [ANGLE_WIDTH-1:0] o_direction,
    output logic                   o_undefined_angle
);

    localparam int SQ_W    = 2 * COORD_WIDTH;
    localparam int XW      = COORD_WIDTH + GUARD_BITS + 2;
    localparam int N_STEPS = (COORD_WIDTH > CORDIC_STAGES) ? COORD_WIDTH : CORDIC_STAGES;

    logic                 front_vld;
    logic [SQ_W-1:0]      front_sq;
    t_flags               front_flags;

    logic [SQ_W-1:0]      w_rem  [N_STEPS+1];
    logic [SQ_W-1:0]      w_root [N_STEPS+1];
    logic signed [XW-1:0] w_x    [N_STEPS+1];
    logic signed [XW-1:0] w_y    [N_STEPS+1];
    logic [TURN_W-1:0]    w_z    [N_STEPS+1];

    logic                 r_vld [N_STEPS];
    logic [SQ_W-1:0]      r_sq  [N_STEPS];
    t_flags               r_flg [N_STEPS];

    assign busy = 1'b0;

    c2p_front #(
        .CW (COORD_WIDTH),
        .XW (XW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_x     (i_x_coord),
        .i_y     (i_y_coord),
        .o_vld   (front_vld),
        .o_sq    (front_sq),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0]),
        .o_flags (front_flags)
    );

    assign w_rem[0]  = front_sq;
    assign w_root[0] = '0;

    generate
        for (genvar k = 0; k < N_STEPS; k++) begin : g_step
            c2p_sqrt_step #(
                .STEPS (COORD_WIDTH),
                .STEP  (k)
            ) u_sqrt (
                .i_clk  (i_clk),
                .i_rem  (w_rem[k]),
                .i_root (w_root[k]),
                .o_rem  (w_rem[k+1]),
                .o_root (w_root[k+1])
            );

            c2p_cordic_step #(
                .XW    (XW),
                .STEPS (CORDIC_STAGES),
                .STEP  (k)
            ) u_cordic (
                .i_clk (i_clk),
                .i_x   (w_x[k]),
                .i_y   (w_y[k]),
                .i_z   (w_z[k]),
                .o_x   (w_x[k+1]),
                .o_y   (w_y[k+1]),
                .o_z   (w_z[k+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= front_vld;
            for (int k = 1; k < N_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq[0]  <= front_sq;
        r_flg[0] <= front_flags;
        for (int k = 1; k < N_STEPS; k++) begin
            r_sq[k]  <= r_sq[k-1];
            r_flg[k] <= r_flg[k-1];
        end
    end

    c2p_back #(
        .CW (COORD_WIDTH),
        .AW (ANGLE_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_vld[N_STEPS-1]),
        .i_sq     (r_sq[N_STEPS-1]),
        .i_rem    (w_rem[N_STEPS]),
        .i_root   (w_root[N_STEPS]),
        .i_z      (w_z[N_STEPS]),
        .i_flags  (r_flg[N_STEPS-1]),
        .o_vld    (o_valid),
        .o_len_sq (o_length_squared),
        .o_len    (o_length),
        .o_dir    (o_direction),
        .o_undef  (o_undefined_angle)
    );

endmodule

/* verif/tb_cartesian_to_polar.sv */
// Self-checking testbench for cartesian_to_polar: directed and random vectors,
// each result checked against a behavioral CORDIC and square-root predictor.
// Depends on c2p_pkg and the cartesian_to_polar RTL.
`timescale 1ns / 1ps

import c2p_pkg::*;

localparam int CW = COORD_WIDTH_DEF;
localparam int AW = ANGLE_WIDTH_DEF;

typedef struct packed {
    logic [LEN_SQ_W-1:0] length_squared;
    logic [LEN_W-1:0]    length;
    logic [AW-1:0]       direction;
    logic                undefined_angle;
} polar_t;

typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    polar_t        polar;
} polar_request_t;

class polar_scoreboard;
    polar_request_t pending_polar[$];
    int unsigned    mismatches = 0;

    function polar_t polar_of(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        longint          sx, sy, cx, cy, dx, dy, z;
        longint unsigned sq, lo, hi, mid, r, a;
        polar_t          p;
        sx = x;
        sy = y;
        sq = sx * sx + sy * sy;
        lo = 0;
        hi = 64'd1 << 17;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= sq) lo = mid;
            else hi = mid - 1;
        end
        r = lo;
        // round half up
        if (sq - r * r > r) r++;
        p.length_squared  = (sq > 64'hFFFF_FFFF) ? '1 : sq[LEN_SQ_W-1:0];
        p.length          = (r > 64'hFFFF) ? '1 : r[LEN_W-1:0];
        p.undefined_angle = 1'b0;
        p.direction       = '0;
        if (sx == 0 && sy == 0) begin
            p.undefined_angle = 1'b1;
        end else if (sy == 0) begin
            p.direction = (sx > 0) ? '0 : AW'(64'd1 << (AW - 1));
        end else if (sx == 0) begin
            p.direction = (sy > 0) ? AW'(64'd1 << (AW - 2)) : AW'(64'd3 << (AW - 2));
        end else begin
            cx = sx;
            cy = sy;
            z  = 0;
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                z  = longint'(HALF_TURN);
            end
            cx = cx <<< GUARD_BITS;
            cy = cy <<< GUARD_BITS;
            for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_LEN; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z  = z + longint'(ATAN_TURNS[i]);
                end else begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z  = z - longint'(ATAN_TURNS[i]);
                end
            end
            a = longint'(z) & 64'hFFFF_FFFF;
            a = (a + (64'd1 << (TURN_W - 1 - AW))) >> (TURN_W - AW);
            p.direction = a[AW-1:0];
        end
        return p;
    endfunction

    function void note_request(logic [CW-1:0] x, logic [CW-1:0] y);
        polar_request_t e;
        e.x     = x;
        e.y     = y;
        e.polar = polar_of(x, y);
        pending_polar.push_back(e);
    endfunction

    function void check_result(polar_t got);
        polar_request_t e;
        if (pending_polar.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result sq=%0d len=%0d dir=%0d undef=%0b",
                     $time, got.length_squared, got.length, got.direction,
                     got.undefined_angle);
            return;
        end
        e = pending_polar.pop_front();
        if (got !== e.polar) begin
            mismatches++;
            $display("%0t: mismatch x=%0d y=%0d expected sq=%0d len=%0d dir=%0d undef=%0b",
                     $time, $signed(e.x), $signed(e.y), e.polar.length_squared,
                     e.polar.length, e.polar.direction, e.polar.undefined_angle);
            $display("%0t:          actual   sq=%0d len=%0d dir=%0d undef=%0b",
                     $time, got.length_squared, got.length, got.direction,
                     got.undefined_angle);
        end
    endfunction

    function int outstanding();
        return pending_polar.size();
    endfunction
endclass

module tb_cartesian_to_polar;

    localparam int RANDOM_REQUESTS = 800;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CW-1:0]       i_x_coord;
    logic [CW-1:0]       i_y_coord;
    logic                o_valid;
    logic [LEN_SQ_W-1:0] o_length_squared;
    logic [LEN_W-1:0]    o_length;
    logic [AW-1:0]       o_direction;
    logic                o_undefined_angle;

    polar_scoreboard sb = new();
    int unsigned     idle_cycles = 0;

    cartesian_to_polar u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_x_coord         (i_x_coord),
        .i_y_coord         (i_y_coord),
        .o_valid           (o_valid),
        .o_length_squared  (o_length_squared),
        .o_length          (o_length),
        .o_direction       (o_direction),
        .o_undefined_angle (o_undefined_angle)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_request(i_x_coord, i_y_coord);
            if (o_valid) begin
                sb.check_result({o_length_squared, o_length, o_direction,
                                 o_undefined_angle});
            end
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(logic [CW-1:0] x, logic [CW-1:0] y);
        @(negedge i_clk);
        start     <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_idle(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start     <= 1'b0;
            i_x_coord <= CW'($urandom);
            i_y_coord <= CW'($urandom);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.outstanding() > 0) @(negedge i_clk);
    endtask

    function automatic logic [CW-1:0] random_coord();
        logic [CW-1:0] corners[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        case ($urandom_range(0, 9))
            5, 6:    return CW'(int'($urandom_range(0, 16)) - 8);
            7:       return corners[$urandom_range(0, 4)];
            8:       return '0;
            9:       return CW'(int'($urandom_range(0, 2000)) - 1000);
            default: return CW'($urandom);
        endcase
    endfunction

    initial begin
        int  edge_x[24] = '{0, 1, 32767, -1, -32768, 0, 0, 0, 0, 1, -1, 1,
                            -1, 32767, -32768, -32768, 32767, -32768, -32768,
                            3, -5, 100, 1, 2};
        int  edge_y[24] = '{0, 0, 0, 0, 0, 1, 32767, -1, -32768, 1, -1, -1,
                            1, 32767, -32768, 32767, -32768, 1, -1,
                            4, 12, -7, 2, 1};
        int  sent;
        int  burst;
        bit  paused;

        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (edge_x[i]) send_request(CW'(edge_x[i]), CW'(edge_y[i]));
        wait_drained();

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_REQUESTS) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < RANDOM_REQUESTS; b++) begin
                send_request(random_coord(), random_coord());
                sent++;
            end
            if (!paused && sent >= RANDOM_REQUESTS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) hold_idle($urandom_range(1, 12));
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/c2p_pkg.sv
hdl/c2p_front.sv
hdl/c2p_sqrt_step.sv
hdl/c2p_cordic_step.sv
hdl/c2p_back.sv
hdl/cartesian_to_polar.sv
verif/tb_cartesian_to_polar.sv
